@@ rtl/iap_pkg.sv @@
// Shared types and constants for the IEC 104 APDU point parser.
`timescale 1ns / 1ps
`default_nettype none

package iap_pkg;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] LEN_MIN    = 8'd4;
  localparam logic [7:0] LEN_MAX    = 8'd253;
  localparam logic [7:0] LEN_ACK    = 8'd10;

  localparam logic [7:0] TYPE_SP    = 8'd1;
  localparam logic [7:0] TYPE_SP_TB = 8'd30;
  localparam logic [7:0] TYPE_NVA   = 8'd9;
  localparam logic [7:0] TYPE_FLT   = 8'd13;
  localparam logic [7:0] TYPE_CNT   = 8'd15;

  localparam logic [7:0] COT_SPONT  = 8'd3;
  localparam logic [7:0] COT_BACK   = 8'd2;
  localparam logic [7:0] COT_REQ    = 8'd5;
  localparam logic [7:0] COT_ACTTRM = 8'd10;

  localparam logic [15:0] STATION_RESET = 16'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int TDATA_W = 72;
  localparam int TUSER_W = 8;

  typedef enum logic [2:0] {
    KIND_SINGLE    = 3'd0,
    KIND_NORMAL    = 3'd1,
    KIND_FLOAT     = 3'd2,
    KIND_COUNTER   = 3'd3,
    KIND_U_FRAME   = 3'd4,
    KIND_S_FRAME   = 3'd5,
    KIND_ACK_DUE   = 3'd6,
    KIND_SYNC_LOST = 3'd7
  } iap_kind_e;

  typedef struct packed {
    iap_kind_e   kind;
    logic [23:0] object_address;
    logic [31:0] value;
    logic [14:0] receive_count;
    logic        last;
  } iap_result_t;

  typedef struct packed {
    logic [1:0]  count;
    iap_result_t first;
    iap_result_t second;
  } iap_push_t;

endpackage

`default_nettype wire

@@ rtl/iap_parser.sv @@
// Byte-wise APDU parser: frame state, receive counter and result generation.
`timescale 1ns / 1ps
`default_nettype none

module iap_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [15:0]        cfg_wdata_i,
  input  wire logic               byte_valid_i,
  input  wire logic [7:0]         byte_i,
  output iap_pkg::iap_push_t      push_o
);
  import iap_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_CONTROL,
    PH_HEADER,
    PH_OBJECTS,
    PH_SKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] station_q;
  logic [7:0]  frame_length_q, frame_length_d;
  logic [7:0]  byte_index_q, byte_index_d;
  logic [31:0] control_word_q, control_word_d;
  logic [7:0]  type_id_q, type_id_d;
  logic [6:0]  object_count_q, object_count_d;
  logic [7:0]  cause_q, cause_d;
  logic [15:0] common_q, common_d;
  logic [3:0]  object_byte_q, object_byte_d;
  logic [23:0] addr_q, addr_d;
  logic [31:0] value_q, value_d;
  logic [14:0] seq_q, seq_d;

  logic        prim_valid;
  iap_kind_e   prim_kind;
  logic [23:0] prim_addr;
  logic [31:0] prim_value;
  logic        ack_valid;
  logic [7:0]  hdr_idx;
  logic [1:0]  ctl_idx;
  logic        type_point;
  logic        decodable;
  logic [3:0]  last_ob;
  logic [6:0]  count_dec;
  iap_result_t prim_res, ack_res;

  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    byte_index_d   = byte_index_q;
    control_word_d = control_word_q;
    type_id_d      = type_id_q;
    object_count_d = object_count_q;
    cause_d        = cause_q;
    common_d       = common_q;
    object_byte_d  = object_byte_q;
    addr_d         = addr_q;
    value_d        = value_q;
    seq_d          = seq_q;
    prim_valid     = 1'b0;
    prim_kind      = KIND_SINGLE;
    prim_addr      = '0;
    prim_value     = '0;
    ack_valid      = 1'b0;
    hdr_idx        = byte_index_q + 8'd1 - 8'd5;
    ctl_idx        = byte_index_q[1:0];
    type_point     = (type_id_q == TYPE_SP) || (type_id_q == TYPE_SP_TB) ||
                     (type_id_q == TYPE_NVA) || (type_id_q == TYPE_FLT);
    decodable      = 1'b0;
    count_dec      = object_count_q - 7'd1;
    case (type_id_q)
      TYPE_SP:    last_ob = 4'd3;
      TYPE_SP_TB: last_ob = 4'd10;
      TYPE_NVA:   last_ob = 4'd5;
      default:    last_ob = 4'd7;
    endcase

    if (byte_valid_i) begin
      case (phase_q)
        PH_HUNT: begin
          if (byte_i == START_BYTE) phase_d = PH_LENGTH;
        end
        PH_LENGTH: begin
          if (byte_i < LEN_MIN || byte_i > LEN_MAX) begin
            prim_valid = 1'b1;
            prim_kind  = KIND_SYNC_LOST;
            prim_value = {24'd0, byte_i};
            phase_d    = PH_HUNT;
          end else begin
            frame_length_d = byte_i;
            byte_index_d   = '0;
            control_word_d = '0;
            phase_d        = PH_CONTROL;
          end
        end
        default: begin
          byte_index_d = byte_index_q + 8'd1;
          case (phase_q)
            PH_CONTROL: begin
              case (ctl_idx)
                2'd0:    control_word_d = control_word_q | {24'd0, byte_i};
                2'd1:    control_word_d = control_word_q | {16'd0, byte_i, 8'd0};
                2'd2:    control_word_d = control_word_q | {8'd0, byte_i, 16'd0};
                default: control_word_d = control_word_q | {byte_i, 24'd0};
              endcase
              if (byte_index_d == 8'd4) begin
                if (control_word_d[1:0] == 2'b11) begin
                  prim_valid = 1'b1;
                  prim_kind  = KIND_U_FRAME;
                  prim_value = control_word_d;
                  phase_d    = PH_SKIP;
                end else if (control_word_d[1:0] == 2'b01) begin
                  prim_valid = 1'b1;
                  prim_kind  = KIND_S_FRAME;
                  prim_value = control_word_d;
                  phase_d    = PH_SKIP;
                end else begin
                  if (frame_length_q > LEN_MIN) seq_d = seq_q + 15'd1;
                  phase_d = PH_HEADER;
                end
              end
            end
            PH_HEADER: begin
              case (hdr_idx)
                8'd0: type_id_d = byte_i;
                8'd1: object_count_d = byte_i[6:0];
                8'd2: cause_d = byte_i;
                8'd4: common_d = {8'd0, byte_i};
                8'd5: begin
                  common_d      = {byte_i, common_q[7:0]};
                  object_byte_d = '0;
                  if (common_d == station_q) begin
                    if (cause_q == COT_SPONT) begin
                      decodable = type_point;
                    end else if (cause_q == COT_BACK || cause_q == COT_REQ ||
                                 cause_q == COT_ACTTRM) begin
                      decodable = type_point || (type_id_q == TYPE_CNT);
                    end
                  end
                  if (!decodable) object_count_d = '0;
                  phase_d = (object_count_d != 7'd0) ? PH_OBJECTS : PH_SKIP;
                end
                default: ;
              endcase
            end
            PH_OBJECTS: begin
              case (object_byte_q)
                4'd0: begin
                  addr_d  = {16'd0, byte_i};
                  value_d = '0;
                end
                4'd1: addr_d = addr_q | {8'd0, byte_i, 8'd0};
                4'd2: addr_d = addr_q | {byte_i, 16'd0};
                4'd3: value_d = value_q | {24'd0, byte_i};
                4'd4: value_d = value_q | {16'd0, byte_i, 8'd0};
                4'd5: value_d = value_q | {8'd0, byte_i, 16'd0};
                4'd6: value_d = value_q | {byte_i, 24'd0};
                default: ;
              endcase
              prim_addr = addr_d;
              if ((type_id_q == TYPE_SP || type_id_q == TYPE_SP_TB) &&
                  object_byte_q == 4'd3) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_SINGLE;
                prim_value = {31'd0, value_d[0]};
              end else if (type_id_q == TYPE_NVA && object_byte_q == 4'd5) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_NORMAL;
                prim_value = {16'd0, value_d[15:0]};
              end else if (type_id_q == TYPE_FLT && object_byte_q == 4'd7) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_FLOAT;
                prim_value = value_d;
              end else if (type_id_q == TYPE_CNT && object_byte_q == 4'd7) begin
                prim_valid = 1'b1;
                prim_kind  = KIND_COUNTER;
                prim_value = value_d;
              end
              if (object_byte_q >= last_ob) begin
                object_byte_d  = '0;
                object_count_d = count_dec;
                if (count_dec == 7'd0) phase_d = PH_SKIP;
              end else begin
                object_byte_d = object_byte_q + 4'd1;
              end
            end
            default: ;
          endcase
          if (byte_index_d >= frame_length_q) begin
            if (!control_word_d[0] && frame_length_q >= LEN_ACK) ack_valid = 1'b1;
            phase_d = PH_HUNT;
          end
        end
      endcase
    end

    prim_res.kind           = prim_kind;
    prim_res.object_address = prim_addr;
    prim_res.value          = prim_value;
    prim_res.receive_count  = seq_d;
    prim_res.last           = !ack_valid;

    ack_res.kind            = KIND_ACK_DUE;
    ack_res.object_address  = '0;
    ack_res.value           = '0;
    ack_res.receive_count   = seq_d;
    ack_res.last            = 1'b1;

    push_o.second = ack_res;
    if (prim_valid) begin
      push_o.first = prim_res;
      push_o.count = ack_valid ? 2'd2 : 2'd1;
    end else begin
      push_o.first = ack_res;
      push_o.count = ack_valid ? 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      station_q      <= STATION_RESET;
      frame_length_q <= '0;
      byte_index_q   <= '0;
      control_word_q <= '0;
      type_id_q      <= '0;
      object_count_q <= '0;
      cause_q        <= '0;
      common_q       <= '0;
      object_byte_q  <= '0;
      addr_q         <= '0;
      value_q        <= '0;
      seq_q          <= '0;
    end else begin
      if (cfg_we_i) station_q <= cfg_wdata_i;
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      byte_index_q   <= byte_index_d;
      control_word_q <= control_word_d;
      type_id_q      <= type_id_d;
      object_count_q <= object_count_d;
      cause_q        <= cause_d;
      common_q       <= common_d;
      object_byte_q  <= object_byte_d;
      addr_q         <= addr_d;
      value_q        <= value_d;
      seq_q          <= seq_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/iap_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per transaction.
`timescale 1ns / 1ps
`default_nettype none

module iap_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire iap_pkg::iap_push_t push_i,
  output logic                    space_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output iap_pkg::iap_result_t    data_o
);
  import iap_pkg::*;

  iap_result_t        entry_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_inc;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (count_q != '0);
  assign space_o    = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign data_o     = entry_q[rd_ptr_q];
  assign wr_ptr_inc = wr_ptr_q + 1'b1;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + FIFO_CW'(push_i.count) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) entry_q[wr_ptr_q] <= push_i.first;
    if (push_i.count == 2'd2) entry_q[wr_ptr_inc] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/iec104_apdu_point_parser_top.sv @@
// IEC 60870-5-104 APDU receiver and point decoder: top level.
//
// Link bytes enter on the s_axis channel, one per transaction. Each byte is
// parsed in the cycle it is taken: frame sync, control field class, receive
// counter and ASDU objects. A byte may cause up to two results (a point or a
// control report, then an acknowledge-due); they leave on the m_axis channel
// one per transaction, the result kind on tuser, tlast marking the final
// result of a byte.
// Results are registered in the result queue and offered on m_axis from its head.
// Throughput: one byte per cycle while the result queue has room for two;
// a byte causing two results costs the output side two transactions.
// cfg_we_i writes the station common address (reset value 1); write it only
// while no results are pending.
// Reset: parser hunts for the start byte, counter clears, queue empties.
// When the receiver stalls the four-entry result queue fills and s_axis_tready
// drops once fewer than two entries are free; results are held, none is lost.
`timescale 1ns / 1ps
`default_nettype none

module iec104_apdu_point_parser_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,   // rx_byte
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // object_address[23:0], value[55:24], receive_count[70:56], zeros
  output logic [iap_pkg::TDATA_W-1:0]        m_axis_tdata_o,
  // kind[2:0], zeros
  output logic [iap_pkg::TUSER_W-1:0]        m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);
  import iap_pkg::*;

  iap_push_t   push;
  iap_result_t head;
  logic        space;
  logic        take;

  assign take            = s_axis_tvalid_i && space;
  assign s_axis_tready_o = space;

  iap_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .byte_valid_i (take),
    .byte_i       (s_axis_tdata_i),
    .push_o       (push)
  );

  iap_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (head)
  );

  assign m_axis_tdata_o = {1'b0, head.receive_count, head.value, head.object_address};
  assign m_axis_tuser_o = {5'd0, head.kind};
  assign m_axis_tlast_o = head.last;

endmodule

`default_nettype wire
